>>> sv/swt_pkg.sv
package swt_pkg;

	// Lexer state codes.
	localparam logic [2:0] LEX_IDLE   = 3'd0;
	localparam logic [2:0] LEX_WORD   = 3'd1;
	localparam logic [2:0] LEX_DQ     = 3'd2;
	localparam logic [2:0] LEX_SQ     = 3'd3;
	localparam logic [2:0] LEX_ESC    = 3'd4;
	localparam logic [2:0] LEX_DQ_BSL = 3'd5;

	// Token kinds on the output channel.
	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_END_WORD = 2'd1;
	localparam logic [1:0] KIND_SEMI     = 2'd2;
	localparam logic [1:0] KIND_EOF      = 2'd3;

	// Special bytes.
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Most tokens one input byte can cause.
	localparam int MAX_TOKS = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} tok_t;

	// All tokens caused by one input item, in order.
	typedef struct packed {
		logic [2:0]                 cnt;
		tok_t [MAX_TOKS-1:0]        tok;
	} bundle_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> sv/swt_in_if.sv
interface swt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       is_last;

	modport source (output valid, output char_code, output has_char, output is_last,
		input ready);
	modport sink (input valid, input char_code, input has_char, input is_last,
		output ready);
endinterface

>>> sv/swt_out_if.sv
interface swt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output out_kind, output out_byte, output run_last,
		input ready);
	modport sink (input valid, input out_kind, input out_byte, input run_last,
		output ready);
endinterface

>>> sv/swt_front.sv
module swt_front
	import swt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	swt_in_if.sink    in_ch,
	input  q_stat_t   q_stat,
	output logic      push,
	output bundle_t   push_bundle
);

	logic [2:0] lex_q;
	logic       nonempty_q;
	logic [2:0] lex_nx;
	logic       nonempty_nx;
	logic       accept;
	logic       idle_go;
	logic [2:0] n;
	tok_t [MAX_TOKS-1:0] tok;
	logic [7:0] c;

	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && !q_stat.full;
	assign c           = in_ch.char_code;

	// Classify the byte and build the tokens it causes, in order.
	always_comb begin
		lex_nx      = lex_q;
		nonempty_nx = nonempty_q;
		n           = 3'd0;
		tok         = '0;
		idle_go     = 1'b0;
		if (in_ch.has_char) begin
			case (lex_q)
				LEX_WORD: begin
					if ((c inside {[CH_TAB:CH_CR], CH_SPACE}) || c == CH_SEMI) begin
						tok[n[1:0]] = '{kind: KIND_END_WORD, data: 8'd0};
						n           = n + 3'd1;
						nonempty_nx = 1'b0;
						idle_go     = 1'b1;
					end else if (c == CH_DQUOTE) begin
						lex_nx = LEX_DQ;
					end else if (c == CH_SQUOTE) begin
						lex_nx = LEX_SQ;
					end else if (c == CH_BSL) begin
						lex_nx = LEX_ESC;
					end else begin
						tok[n[1:0]] = '{kind: KIND_BYTE, data: c};
						n           = n + 3'd1;
						nonempty_nx = 1'b1;
					end
				end
				LEX_DQ: begin
					if (c == CH_DQUOTE) begin
						lex_nx = LEX_WORD;
					end else if (c == CH_BSL) begin
						lex_nx = LEX_DQ_BSL;
					end else begin
						tok[n[1:0]] = '{kind: KIND_BYTE, data: c};
						n           = n + 3'd1;
						nonempty_nx = 1'b1;
					end
				end
				LEX_SQ: begin
					if (c == CH_SQUOTE) begin
						lex_nx = LEX_WORD;
					end else begin
						tok[n[1:0]] = '{kind: KIND_BYTE, data: c};
						n           = n + 3'd1;
						nonempty_nx = 1'b1;
					end
				end
				LEX_ESC: begin
					tok[n[1:0]] = '{kind: KIND_BYTE, data: c};
					n           = n + 3'd1;
					nonempty_nx = 1'b1;
					lex_nx      = LEX_WORD;
				end
				LEX_DQ_BSL: begin
					if (!(c inside {CH_DQUOTE, CH_BSL, CH_DOLLAR})) begin
						tok[n[1:0]] = '{kind: KIND_BYTE, data: CH_BSL};
						n           = n + 3'd1;
					end
					tok[n[1:0]] = '{kind: KIND_BYTE, data: c};
					n           = n + 3'd1;
					nonempty_nx = 1'b1;
					lex_nx      = LEX_DQ;
				end
				default: begin
					idle_go = 1'b1;
				end
			endcase

			// Start of a token from the between-words state.
			if (idle_go) begin
				lex_nx = LEX_IDLE;
				if (c inside {[CH_TAB:CH_CR], CH_SPACE}) begin
					lex_nx = LEX_IDLE;
				end else if (c == CH_SEMI) begin
					tok[n[1:0]] = '{kind: KIND_SEMI, data: 8'd0};
					n           = n + 3'd1;
				end else if (c == CH_DQUOTE) begin
					lex_nx = LEX_DQ;
				end else if (c == CH_SQUOTE) begin
					lex_nx = LEX_SQ;
				end else if (c == CH_BSL) begin
					lex_nx = LEX_ESC;
				end else begin
					tok[n[1:0]] = '{kind: KIND_BYTE, data: c};
					n           = n + 3'd1;
					nonempty_nx = 1'b1;
					lex_nx      = LEX_WORD;
				end
			end
		end

		// End of line: flush a pending backslash, close the word, mark the end.
		if (in_ch.is_last) begin
			if (lex_nx == LEX_DQ_BSL) begin
				tok[n[1:0]] = '{kind: KIND_BYTE, data: CH_BSL};
				n           = n + 3'd1;
				nonempty_nx = 1'b1;
			end
			if (nonempty_nx) begin
				tok[n[1:0]] = '{kind: KIND_END_WORD, data: 8'd0};
				n           = n + 3'd1;
			end
			tok[n[1:0]] = '{kind: KIND_EOF, data: 8'd0};
			n           = n + 3'd1;
			lex_nx      = LEX_IDLE;
			nonempty_nx = 1'b0;
		end
	end

	assign push            = accept && (n != 3'd0);
	assign push_bundle.cnt = n;
	assign push_bundle.tok = tok;

	// Lexer state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q      <= LEX_IDLE;
			nonempty_q <= 1'b0;
		end else if (accept) begin
			lex_q      <= lex_nx;
			nonempty_q <= nonempty_nx;
		end
	end

endmodule

>>> sv/swt_queue.sv
module swt_queue
	import swt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_bundle,
	input  logic    pop,
	output bundle_t head,
	output q_stat_t q_stat
);

	bundle_t    mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	// Two-entry bundle queue between the front and back parts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Payload storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_bundle;
		end
	end

endmodule

>>> sv/swt_back.sv
module swt_back
	import swt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bundle_t   head,
	input  q_stat_t   q_stat,
	output logic      pop,
	swt_out_if.source out_ch
);

	bundle_t    bun_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       at_last;
	logic       xfer;
	tok_t       cur;

	assign cur     = bun_q.tok[idx_q];
	assign at_last = ({1'b0, idx_q} == (bun_q.cnt - 3'd1));
	assign xfer    = busy_q && out_ch.ready;
	assign pop     = !q_stat.empty && (!busy_q || (xfer && at_last));

	assign out_ch.valid    = busy_q;
	assign out_ch.out_kind = cur.kind;
	assign out_ch.out_byte = cur.data;
	assign out_ch.run_last = at_last;

	// Step through the tokens of the held bundle, one transfer each.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (xfer) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bun_q <= head;
		end
	end

endmodule

>>> sv/shell_word_tokenizer_core.sv
// Each input byte's tokens go through the bundle queue into the output stage's held bundle
// before they are offered. Throughput: one input byte per cycle while each byte causes at
// most one token and the output is ready; a byte causing more than one token holds the
// output longer, and a two-entry bundle queue absorbs that. The output side, stepping one
// token per cycle while the output is ready, sets the sustained rate.
// Reset clears the lexer state, the queue pointers and the output stage at once.
module shell_word_tokenizer_core
	import swt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	swt_in_if.sink    in_ch,
	swt_out_if.source out_ch
);

	logic    push;
	logic    pop;
	bundle_t push_bundle;
	bundle_t head;
	q_stat_t q_stat;

	swt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.q_stat      (q_stat),
		.push        (push),
		.push_bundle (push_bundle)
	);

	swt_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.head        (head),
		.q_stat      (q_stat)
	);

	swt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
